FILE: src/lfg_pkg.sv
// ----------------------------------------------------------------------------
// Line fragment generator package
// Shared payload types, command/status structs and opcodes.
// ----------------------------------------------------------------------------
package lfg_pkg;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_STEP = 1'b1;

	typedef struct packed {
		logic               kind;
		logic signed [15:0] x_start;
		logic signed [15:0] y_start;
		logic signed [15:0] x_end;
		logic signed [15:0] y_end;
		logic signed [31:0] depth_start;
		logic signed [31:0] depth_end;
		logic        [15:0] gray_start;
		logic        [15:0] gray_end;
	} in_word_t;

	typedef struct packed {
		logic               valid_res;
		logic signed [15:0] pixel_x;
		logic signed [15:0] pixel_y;
		logic signed [31:0] depth;
		logic        [15:0] gray;
		logic               last;
	} out_word_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic load;      // capture word and set up segment
		logic div_start; // launch the increment divide
		logic step;      // advance one pixel
		logic emit;      // place a fragment in the output register
		logic emit_idle; // place an all-zero word in the output register
	} lfg_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic div_done;
		logic active;
	} lfg_sts_t;

endpackage

FILE: src/lfg_div.sv
// ----------------------------------------------------------------------------
// Line fragment generator divider
// Restoring signed divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module lfg_div import lfg_pkg::*; #(
	parameter int NUM_BITS = 64,
	parameter int DEN_BITS = 17
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [NUM_BITS-1:0] num,
	input  logic        [DEN_BITS-1:0] den,
	output logic                       done,
	output logic signed [NUM_BITS-1:0] quo
);
	localparam int CW = $clog2(NUM_BITS + 1);

	logic [NUM_BITS-1:0] mag_q;
	logic [DEN_BITS-1:0] den_q;
	logic [DEN_BITS:0]   rem_q;
	logic                neg_q;
	logic [CW-1:0]       cnt_q;
	logic                busy_q;
	logic [DEN_BITS:0]   trial;
	logic [DEN_BITS:0]   shifted;

	assign shifted = {rem_q[DEN_BITS-1:0], mag_q[NUM_BITS-1]};
	assign trial   = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[NUM_BITS-1];
			mag_q <= num[NUM_BITS-1] ? NUM_BITS'(-num) : num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[DEN_BITS]) begin
				rem_q <= trial;
				mag_q <= {mag_q[NUM_BITS-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				mag_q <= {mag_q[NUM_BITS-2:0], 1'b0};
			end
		end
	end

	assign quo = neg_q ? NUM_BITS'(-mag_q) : mag_q;
endmodule

FILE: src/lfg_datapath.sv
// ----------------------------------------------------------------------------
// Line fragment generator datapath
// Segment set-up, Bresenham stepping, attribute accumulators, output register.
// ----------------------------------------------------------------------------
module lfg_datapath import lfg_pkg::*; #(
	parameter int COORD_BITS     = 16,
	parameter int INCR_FRAC_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_word_t  in_word,
	input  lfg_cmd_t  cmd,
	output lfg_sts_t  sts,
	output out_word_t out_word
);
	localparam int CB  = COORD_BITS;
	localparam int F   = INCR_FRAC_BITS;
	localparam int DW  = 33 + F + 1;      // depth diff scaled
	localparam int GW  = 17 + F + 1;
	localparam int NW  = DW;              // shared divider width
	localparam int LW  = CB + 1;

	logic signed [CB-1:0] x1, y1, x2, y2, ax1, ay1, ax2, ay2, mj1, mn1, mj2, mn2;
	logic signed [CB:0]   dx, dy, adx, ady, len, dmin;
	logic                 swp, ordr;
	logic signed [32:0]   d1, d2;
	logic signed [17:0]   g1, g2;

	logic                 swp_q, neg_q, active_q;
	logic signed [CB:0]   mpos_q, mstop_q, npos_q;
	logic signed [CB+3:0] err_q, eup_q, edn_q, err_n;
	logic signed [DW-1:0] dacc_q, dinc_q;
	logic signed [GW-1:0] gacc_q, ginc_q;
	logic signed [DW-1:0] dnum_q;
	logic signed [GW-1:0] gnum_q;
	logic [LW-1:0]        len_q;
	logic                 phase_q;
	logic                 div_start_q;
	logic                 div_done_q;
	logic signed [NW-1:0] div_num, div_quo;
	logic                 div_done;

	always_comb begin
		x1 = CB'(in_word.x_start); y1 = CB'(in_word.y_start);
		x2 = CB'(in_word.x_end);   y2 = CB'(in_word.y_end);
		dx = (CB+1)'(x2) - (CB+1)'(x1);
		dy = (CB+1)'(y2) - (CB+1)'(y1);
		adx = dx[CB] ? -dx : dx;
		ady = dy[CB] ? -dy : dy;
		swp = ady > adx;
		ax1 = swp ? y1 : x1; ay1 = swp ? x1 : y1;
		ax2 = swp ? y2 : x2; ay2 = swp ? x2 : y2;
		ordr = ax1 > ax2;
		mj1 = ordr ? ax2 : ax1; mn1 = ordr ? ay2 : ay1;
		mj2 = ordr ? ax1 : ax2; mn2 = ordr ? ay1 : ay2;
		d1 = ordr ? 33'(in_word.depth_end) : 33'(in_word.depth_start);
		d2 = ordr ? 33'(in_word.depth_start) : 33'(in_word.depth_end);
		g1 = ordr ? 18'(in_word.gray_end) : 18'(in_word.gray_start);
		g2 = ordr ? 18'(in_word.gray_start) : 18'(in_word.gray_end);
		len  = (CB+1)'(mj2) - (CB+1)'(mj1);
		dmin = (CB+1)'(mn2) - (CB+1)'(mn1);
	end

	assign err_n = err_q + eup_q;
	assign div_num = phase_q ? NW'(gnum_q) : dnum_q;

	lfg_div #(.NUM_BITS(NW), .DEN_BITS(LW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start_q),
		.num(div_num), .den(len_q), .done(div_done), .quo(div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			phase_q     <= 1'b0;
			div_start_q <= 1'b0;
			div_done_q  <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			div_done_q  <= 1'b0;
			if (cmd.div_start) begin
				phase_q     <= 1'b0;
				div_start_q <= 1'b1;
			end else if (div_done && !phase_q) begin
				phase_q     <= 1'b1;
				div_start_q <= 1'b1;
			end else if (div_done) begin
				div_done_q <= 1'b1;
			end
			if (cmd.load)
				active_q <= 1'b1;
			else if (cmd.emit && mpos_q >= mstop_q)
				active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			swp_q   <= swp;
			neg_q   <= mn2 < mn1;
			mpos_q  <= (CB+1)'(mj1);
			mstop_q <= (CB+1)'(mj2);
			npos_q  <= (CB+1)'(mn1);
			err_q   <= -(CB+4)'(len);
			eup_q   <= (CB+4)'(dmin[CB] ? -dmin : dmin) <<< 1;
			edn_q   <= -((CB+4)'(len) <<< 1);
			dacc_q  <= DW'(d1) <<< F;
			gacc_q  <= GW'(g1) <<< F;
			dnum_q  <= (DW'(d2) - DW'(d1)) <<< F;
			gnum_q  <= (GW'(g2) - GW'(g1)) <<< F;
			len_q   <= LW'(len);
			dinc_q  <= '0;
			ginc_q  <= '0;
		end else begin
			if (div_done && len_q != '0) begin
				if (!phase_q) dinc_q <= div_quo;
				else          ginc_q <= GW'(div_quo);
			end
			if (cmd.step) begin
				mpos_q <= mpos_q + 1'b1;
				if (err_n > 0) begin
					npos_q <= neg_q ? npos_q - 1'b1 : npos_q + 1'b1;
					err_q  <= err_n + edn_q;
				end else begin
					err_q <= err_n;
				end
				dacc_q <= dacc_q + dinc_q;
				gacc_q <= gacc_q + ginc_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_word.valid_res <= 1'b1;
			out_word.pixel_x   <= 16'(swp_q ? npos_q : mpos_q);
			out_word.pixel_y   <= 16'(swp_q ? mpos_q : npos_q);
			out_word.depth     <= dacc_q[F+31:F];
			out_word.gray      <= gacc_q[F+15:F];
			out_word.last      <= mpos_q >= mstop_q;
		end else if (cmd.emit_idle) begin
			out_word <= '0;
		end
	end

	assign sts = '{div_done: div_done_q, active: active_q};
endmodule

FILE: src/lfg_ctrl.sv
// ----------------------------------------------------------------------------
// Line fragment generator controller
// Sequences load, divide, step and emit; owns both handshakes.
// ----------------------------------------------------------------------------
module lfg_ctrl import lfg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_kind,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  lfg_sts_t sts,
	output lfg_cmd_t cmd
);
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_STEP = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t state_q, state_n;
	logic   ov_q, ov_n;
	logic   acc;

	assign in_ready  = (state_q == ST_IDLE) && (!ov_q || out_ready);
	assign out_valid = ov_q;
	assign acc       = in_valid && in_ready;

	always_comb begin
		state_n = state_q;
		ov_n    = ov_q && !out_ready;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (in_kind == KIND_LOAD) begin
						cmd.load      = 1'b1;
						cmd.div_start = 1'b1;
						state_n       = ST_DIV;
					end else if (sts.active) begin
						cmd.step = 1'b1;
						state_n  = ST_EMIT;
					end else begin
						cmd.emit_idle = 1'b1;
						ov_n          = 1'b1;
					end
				end
			end
			ST_DIV: if (sts.div_done) state_n = ST_EMIT;
			ST_STEP: state_n = ST_EMIT;
			ST_EMIT: begin
				cmd.emit = 1'b1;
				ov_n     = 1'b1;
				state_n  = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_n;
			ov_q    <= ov_n;
		end
	end
endmodule

FILE: src/line_fragment_generator_top.sv
// ----------------------------------------------------------------------------
// Line fragment generator
// Bresenham line stepper with depth and gray interpolation.
// ----------------------------------------------------------------------------
//  channel  | signals                        | direction
//  in       | in_valid, in_ready, in_word    | into block
//  out      | out_valid, out_ready, out_word | out of block
//
// A step word advances the stepper on acceptance and its fragment is registered
// in ST_EMIT, so the next word waits until the controller is idle again.
// A load word's fragment is registered in ST_EMIT once the shared
// one-bit-per-cycle divider has computed the depth increment and then
// the gray increment in turn.
// Reset clears the controller, the active flag and the output valid.
// A new word is accepted only when the controller is idle and the output
// register is empty or being emptied in the same cycle.
module line_fragment_generator_top import lfg_pkg::*; #(
	parameter int COORD_BITS     = 16,
	parameter int INCR_FRAC_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_word,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_word
);
	lfg_cmd_t cmd;
	lfg_sts_t sts;

	// The controller owns both handshakes and the output-valid flag.
	lfg_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_kind(in_word.kind),
		.in_ready(in_ready), .out_valid(out_valid), .out_ready(out_ready),
		.sts(sts), .cmd(cmd)
	);

	// The datapath holds the segment state and the output register.
	lfg_datapath #(.COORD_BITS(COORD_BITS), .INCR_FRAC_BITS(INCR_FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_word(in_word), .cmd(cmd),
		.sts(sts), .out_word(out_word)
	);
endmodule

FILE: src/lfg_checker.sv
// ----------------------------------------------------------------------------
// Line fragment generator checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module lfg_checker import lfg_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_word_t out_word
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("output word changed while stalled");

	a_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input accepted while output stalled");

	a_zero_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.valid_res |-> out_word.last == 1'b0 && out_word.gray == 16'd0)
		else $error("idle response not zero");
endmodule

bind line_fragment_generator_top lfg_checker u_lfg_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
);
